// ===== rtl/wfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfa_pkg
// Widths, constants, HT rate table and inter-stage types of the frame
// airtime calculator.
// ----------------------------------------------------------------------------
package wfa_pkg;

  localparam int LEN_W  = 16;  // frame length
  localparam int LRATE_W = 8;  // legacy rate, 500 kbps units
  localparam int MCS_W  = 8;
  localparam int BW_W   = 2;
  localparam int RATE_W = 13;  // rate in 100 kbps units, max 6000
  localparam int DEN_W  = 15;  // divisor, max 4 * 6000
  localparam int NUM_W  = 23;  // dividend incl. ceiling bias
  localparam int DUR_W  = 21;

  // default quotient bits resolved per divider stage
  localparam int DIV_STEP = 4;

  localparam logic [BW_W-1:0] BW_40MHZ = 2'd1;

  // DSSS/CCK rates, 100 kbps units
  localparam logic [RATE_W-1:0] RATE_1M  = 13'd10;
  localparam logic [RATE_W-1:0] RATE_2M  = 13'd20;
  localparam logic [RATE_W-1:0] RATE_5M5 = 13'd55;
  localparam logic [RATE_W-1:0] RATE_11M = 13'd110;

  // SIFS plus preamble/header, DSSS
  localparam logic [DUR_W-1:0] DSSS_OVH_SHORT = 21'(10 + 72 + 24);
  localparam logic [DUR_W-1:0] DSSS_OVH_LONG  = 21'(10 + 144 + 48);
  // SIFS + preamble + signal field, OFDM
  localparam logic [DUR_W-1:0] OFDM_OVH       = 21'(16 + 16 + 4);
  // service and tail bits, scaled by ten
  localparam logic [NUM_W-1:0] OFDM_BITS_ADD  = 23'((16 + 6) * 10);

  // HT rates, column = {bw40, sgi}
  localparam logic [RATE_W-1:0] HT_RATE [32][4] = '{
    '{13'd65,   13'd72,   13'd135,  13'd150},
    '{13'd130,  13'd144,  13'd270,  13'd300},
    '{13'd195,  13'd217,  13'd405,  13'd450},
    '{13'd260,  13'd289,  13'd540,  13'd600},
    '{13'd390,  13'd433,  13'd810,  13'd900},
    '{13'd520,  13'd578,  13'd1080, 13'd1200},
    '{13'd585,  13'd650,  13'd1215, 13'd1350},
    '{13'd650,  13'd722,  13'd1350, 13'd1500},
    '{13'd130,  13'd144,  13'd270,  13'd300},
    '{13'd260,  13'd289,  13'd540,  13'd600},
    '{13'd390,  13'd433,  13'd810,  13'd900},
    '{13'd520,  13'd578,  13'd1080, 13'd1200},
    '{13'd780,  13'd867,  13'd1620, 13'd1800},
    '{13'd1040, 13'd1156, 13'd2160, 13'd2400},
    '{13'd1170, 13'd1300, 13'd2430, 13'd2700},
    '{13'd1300, 13'd1444, 13'd2700, 13'd3000},
    '{13'd195,  13'd217,  13'd405,  13'd450},
    '{13'd390,  13'd433,  13'd810,  13'd900},
    '{13'd585,  13'd650,  13'd1215, 13'd1350},
    '{13'd780,  13'd867,  13'd1620, 13'd1800},
    '{13'd1170, 13'd1300, 13'd2430, 13'd2700},
    '{13'd1560, 13'd1733, 13'd3240, 13'd3600},
    '{13'd1755, 13'd1950, 13'd3645, 13'd4050},
    '{13'd1950, 13'd2167, 13'd4050, 13'd4500},
    '{13'd260,  13'd288,  13'd540,  13'd600},
    '{13'd520,  13'd576,  13'd1080, 13'd1200},
    '{13'd780,  13'd868,  13'd1620, 13'd1800},
    '{13'd1040, 13'd1156, 13'd2160, 13'd2400},
    '{13'd1560, 13'd1732, 13'd3240, 13'd3600},
    '{13'd2080, 13'd2312, 13'd4320, 13'd4800},
    '{13'd2340, 13'd2600, 13'd4860, 13'd5400},
    '{13'd2600, 13'd2888, 13'd5400, 13'd6000}
  };

  typedef struct packed {
    logic err;    // zero rate or unknown MCS
    logic dsss;   // DSSS/CCK formula
    logic spre;   // short preamble
  } wfa_flags_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    wfa_flags_t       flags;
  } wfa_div_req_t;

  typedef struct packed {
    logic [NUM_W-1:0] quo;
    wfa_flags_t       flags;
  } wfa_div_rsp_t;

endpackage

// ===== rtl/wfa_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfa_ifs
// Valid/ready stream interfaces for frame descriptors and airtime results.
// ----------------------------------------------------------------------------
interface wfa_in_if;
  logic                        valid;
  logic                        ready;
  logic [wfa_pkg::LEN_W-1:0]   frame_length;
  logic                        is_legacy_rate;
  logic [wfa_pkg::LRATE_W-1:0] legacy_rate;
  logic [wfa_pkg::MCS_W-1:0]   mcs_index;
  logic [wfa_pkg::BW_W-1:0]    bandwidth_code;
  logic                        short_gi;
  logic                        short_plcp;

  modport source (
    output valid, frame_length, is_legacy_rate, legacy_rate, mcs_index,
           bandwidth_code, short_gi, short_plcp,
    input  ready
  );
  modport sink (
    input  valid, frame_length, is_legacy_rate, legacy_rate, mcs_index,
           bandwidth_code, short_gi, short_plcp,
    output ready
  );
endinterface

interface wfa_out_if;
  logic                      valid;
  logic                      ready;
  logic [wfa_pkg::DUR_W-1:0] duration_us;
  logic                      rate_error;

  modport source (output valid, duration_us, rate_error, input ready);
  modport sink   (input valid, duration_us, rate_error, output ready);
endinterface

// ===== rtl/wfa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfa_front
// Input register, rate lookup and dividend/divisor setup (three stages).
// ----------------------------------------------------------------------------
module wfa_front (
  input  logic                  clk,
  input  logic                  rst_n,
  wfa_in_if.sink                in_chan,
  output logic                  req_vld,
  input  logic                  req_rdy,
  output wfa_pkg::wfa_div_req_t req
);

  // stage A: captured descriptor
  logic                        a_vld_r;
  logic [wfa_pkg::LEN_W-1:0]   a_len_r;
  logic                        a_leg_r;
  logic [wfa_pkg::LRATE_W-1:0] a_lrate_r;
  logic [wfa_pkg::MCS_W-1:0]   a_mcs_r;
  logic [wfa_pkg::BW_W-1:0]    a_bw_r;
  logic                        a_sgi_r;
  logic                        a_spre_r;

  // stage B: rate and scaled length
  logic                        b_vld_r;
  logic [wfa_pkg::RATE_W-1:0]  b_rate_r, b_rate_nxt;
  logic [wfa_pkg::NUM_W-1:0]   b_base_r, b_base_nxt;
  logic                        b_spre_r;

  // stage C: divider request
  logic                        c_vld_r;
  wfa_pkg::wfa_div_req_t       c_req_r, c_req_nxt;

  logic a_rdy, b_rdy, c_rdy;

  assign c_rdy = !c_vld_r || req_rdy;
  assign b_rdy = !b_vld_r || c_rdy;
  assign a_rdy = !a_vld_r || b_rdy;

  assign in_chan.ready = a_rdy;
  assign req_vld       = c_vld_r;
  assign req           = c_req_r;

  always_comb begin
    logic [wfa_pkg::LEN_W:0] lenp4;
    logic [1:0]              col;
    lenp4 = {1'b0, a_len_r} + 17'd4;
    // 80 * (len + 4) = 64x + 16x
    b_base_nxt = {lenp4, 6'b0} + {2'b0, lenp4, 4'b0};
    col = {a_bw_r == wfa_pkg::BW_40MHZ, a_sgi_r};
    if (a_leg_r) begin
      b_rate_nxt = {3'b0, a_lrate_r, 2'b00} + {5'b0, a_lrate_r};
    end else if (a_mcs_r[7:5] == 3'b000) begin
      b_rate_nxt = wfa_pkg::HT_RATE[a_mcs_r[4:0]][col];
    end else begin
      b_rate_nxt = '0;
    end
  end

  always_comb begin
    logic err, dsss;
    logic [wfa_pkg::DEN_W-1:0] den;
    err  = (b_rate_r == '0);
    dsss = (b_rate_r == wfa_pkg::RATE_1M)  || (b_rate_r == wfa_pkg::RATE_2M) ||
           (b_rate_r == wfa_pkg::RATE_5M5) || (b_rate_r == wfa_pkg::RATE_11M);
    den  = dsss ? {2'b0, b_rate_r} : {b_rate_r, 2'b00};
    c_req_nxt.flags.err  = err;
    c_req_nxt.flags.dsss = dsss;
    c_req_nxt.flags.spre = b_spre_r;
    if (err) begin
      // keep the divider clean; result is forced to zero later
      c_req_nxt.num = '0;
      c_req_nxt.den = 15'd1;
    end else begin
      // ceiling bias: + den - 1
      c_req_nxt.num = b_base_r + (dsss ? 23'd0 : wfa_pkg::OFDM_BITS_ADD)
                      + {8'b0, den} - 23'd1;
      c_req_nxt.den = den;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      if (a_rdy) a_vld_r <= in_chan.valid;
      if (b_rdy) b_vld_r <= a_vld_r;
      if (c_rdy) c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && in_chan.valid) begin
      a_len_r   <= in_chan.frame_length;
      a_leg_r   <= in_chan.is_legacy_rate;
      a_lrate_r <= in_chan.legacy_rate;
      a_mcs_r   <= in_chan.mcs_index;
      a_bw_r    <= in_chan.bandwidth_code;
      a_sgi_r   <= in_chan.short_gi;
      a_spre_r  <= in_chan.short_plcp;
    end
    if (b_rdy && a_vld_r) begin
      b_rate_r <= b_rate_nxt;
      b_base_r <= b_base_nxt;
      b_spre_r <= a_spre_r;
    end
    if (c_rdy && b_vld_r) begin
      c_req_r <= c_req_nxt;
    end
  end

endmodule

// ===== rtl/wfa_div_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfa_div_pipe
// Pipelined restoring divider, DIV_STEP quotient bits per stage.
// ----------------------------------------------------------------------------
module wfa_div_pipe #(
  parameter int DIV_STEP = wfa_pkg::DIV_STEP
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  req_vld,
  output logic                  req_rdy,
  input  wfa_pkg::wfa_div_req_t req,
  output logic                  rsp_vld,
  input  logic                  rsp_rdy,
  output wfa_pkg::wfa_div_rsp_t rsp
);

  localparam int NSTG = (wfa_pkg::NUM_W + DIV_STEP - 1) / DIV_STEP;

  logic                      vld_r   [NSTG];
  logic [wfa_pkg::DEN_W-1:0] rem_r   [NSTG];
  logic [wfa_pkg::NUM_W-1:0] nq_r    [NSTG];  // dividend bits shift out, quotient in
  logic [wfa_pkg::DEN_W-1:0] den_r   [NSTG];
  wfa_pkg::wfa_flags_t       flg_r   [NSTG];

  logic                      vld_in  [NSTG];
  logic [wfa_pkg::DEN_W-1:0] den_in  [NSTG];
  wfa_pkg::wfa_flags_t       flg_in  [NSTG];
  logic [wfa_pkg::DEN_W-1:0] rem_nxt [NSTG];
  logic [wfa_pkg::NUM_W-1:0] nq_nxt  [NSTG];
  logic                      rdy     [NSTG];

  always_comb begin
    for (int s = NSTG - 1; s >= 0; s--) begin
      if (s == NSTG - 1) rdy[s] = !vld_r[s] || rsp_rdy;
      else               rdy[s] = !vld_r[s] || rdy[s+1];
    end
  end

  always_comb begin
    logic [wfa_pkg::DEN_W-1:0] rem_t;
    logic [wfa_pkg::NUM_W-1:0] nq_t;
    logic [wfa_pkg::DEN_W:0]   trial;
    logic                      ge;
    for (int s = 0; s < NSTG; s++) begin
      if (s == 0) begin
        vld_in[s] = req_vld;
        den_in[s] = req.den;
        flg_in[s] = req.flags;
        rem_t     = '0;
        nq_t      = req.num;
      end else begin
        vld_in[s] = vld_r[s-1];
        den_in[s] = den_r[s-1];
        flg_in[s] = flg_r[s-1];
        rem_t     = rem_r[s-1];
        nq_t      = nq_r[s-1];
      end
      for (int j = 0; j < DIV_STEP; j++) begin
        if (s * DIV_STEP + j < wfa_pkg::NUM_W) begin
          trial = {rem_t, nq_t[wfa_pkg::NUM_W-1]};
          ge    = (trial >= {1'b0, den_in[s]});
          nq_t  = {nq_t[wfa_pkg::NUM_W-2:0], ge};
          if (ge) trial = trial - {1'b0, den_in[s]};
          rem_t = trial[wfa_pkg::DEN_W-1:0];
        end
      end
      rem_nxt[s] = rem_t;
      nq_nxt[s]  = nq_t;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NSTG; s++) begin
      if (!rst_n) vld_r[s] <= 1'b0;
      else if (rdy[s]) vld_r[s] <= vld_in[s];
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NSTG; s++) begin
      if (rdy[s] && vld_in[s]) begin
        rem_r[s] <= rem_nxt[s];
        nq_r[s]  <= nq_nxt[s];
        den_r[s] <= den_in[s];
        flg_r[s] <= flg_in[s];
      end
    end
  end

  assign req_rdy   = rdy[0];
  assign rsp_vld   = vld_r[NSTG-1];
  assign rsp.quo   = nq_r[NSTG-1];
  assign rsp.flags = flg_r[NSTG-1];

endmodule

// ===== rtl/wfa_dur_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfa_dur_stage
// Adds PHY overhead to the OFDM symbol or DSSS microsecond count and holds the result register.
// ----------------------------------------------------------------------------
module wfa_dur_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rsp_vld,
  output logic                  rsp_rdy,
  input  wfa_pkg::wfa_div_rsp_t rsp,
  wfa_out_if.source             out_chan
);

  logic                      out_vld_r;
  logic [wfa_pkg::DUR_W-1:0] dur_r, dur_nxt;
  logic                      err_r;

  assign rsp_rdy = !out_vld_r || out_chan.ready;

  always_comb begin
    if (rsp.flags.err) begin
      dur_nxt = '0;
    end else if (rsp.flags.dsss) begin
      dur_nxt = (rsp.flags.spre ? wfa_pkg::DSSS_OVH_SHORT : wfa_pkg::DSSS_OVH_LONG)
                + rsp.quo[wfa_pkg::DUR_W-1:0];
    end else begin
      // four microseconds per OFDM symbol
      dur_nxt = wfa_pkg::OFDM_OVH + {rsp.quo[wfa_pkg::DUR_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (rsp_rdy) out_vld_r <= rsp_vld;
  end

  always_ff @(posedge clk) begin
    if (rsp_rdy && rsp_vld) begin
      dur_r <= dur_nxt;
      err_r <= rsp.flags.err;
    end
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.duration_us = dur_r;
  assign out_chan.rate_error  = err_r;

endmodule

// ===== rtl/wifi_frame_airtime_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wifi_frame_airtime_top
// 802.11 frame air time (SIFS included) from a frame descriptor.
// ----------------------------------------------------------------------------
// One frame descriptor in, one result out, one transfer per cycle sustained
// while the result side stays ready. The pipeline is the input register,
// rate lookup, dividend/divisor setup, the divider stages and the output
// register. The divider resolves DIV_STEP quotient bits of the 23-bit
// ceiling dividend per stage, which sets the pipeline depth.
// Every stage has its own valid bit and a stage takes a new transfer when
// it is empty or its successor moves, so bubbles collapse and the input
// keeps accepting while a finished result waits at the output. A zero rate
// or an MCS index above 31 returns rate_error with duration_us of zero.
// ----------------------------------------------------------------------------
module wifi_frame_airtime_top #(
  parameter int DIV_STEP = wfa_pkg::DIV_STEP   // 1..8
) (
  input  logic      clk,
  input  logic      rst_n,
  wfa_in_if.sink    in_chan,
  wfa_out_if.source out_chan
);

  // front end -> divider
  logic                  req_vld;
  logic                  req_rdy;
  wfa_pkg::wfa_div_req_t req;

  // divider -> output stage
  logic                  rsp_vld;
  logic                  rsp_rdy;
  wfa_pkg::wfa_div_rsp_t rsp;

  // stages A..C: capture, rate lookup, dividend = (len bits [+ OFDM service/tail]) * 10 + bias
  wfa_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .req_vld (req_vld),
    .req_rdy (req_rdy),
    .req     (req)
  );

  // ceil division: DSSS microseconds or OFDM symbols
  wfa_div_pipe #(
    .DIV_STEP (DIV_STEP)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .req_vld (req_vld),
    .req_rdy (req_rdy),
    .req     (req),
    .rsp_vld (rsp_vld),
    .rsp_rdy (rsp_rdy),
    .rsp     (rsp)
  );

  // overhead add and output register
  wfa_dur_stage u_dur (
    .clk      (clk),
    .rst_n    (rst_n),
    .rsp_vld  (rsp_vld),
    .rsp_rdy  (rsp_rdy),
    .rsp      (rsp),
    .out_chan (out_chan)
  );

  // error results carry no duration
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.rate_error |-> out_chan.duration_us == '0)
    else $error("rate error with nonzero duration");

  // a good frame takes at least SIFS, preamble and one OFDM symbol
  a_min_dur: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.rate_error |-> out_chan.duration_us >= 21'd40)
    else $error("duration below minimum frame air time");

  // an empty output register means the whole pipe can advance
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_chan.valid |-> in_chan.ready)
    else $error("input stalled while output is empty");

  // no result right after reset
  a_rst_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_chan.valid)
    else $error("result valid right after reset");

endmodule

// ===== verif/tb_wifi_frame_airtime_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wifi_frame_airtime_top
// Self-checking bench for the 802.11 frame air time calculator.
// ----------------------------------------------------------------------------
// A table of directed frames (rate errors, DSSS/CCK and OFDM rates, HT MCS
// corners, extreme lengths, ignored fields) is followed by a random stream
// of frame descriptors. Each accepted frame takes its expected air time from
// its row where typed, else a local calculation, and is queued; every result
// transfer is checked in order against the head of that queue. Both channels
// idle in random bursts, the result side holds off for a long stretch once so
// the pipeline fills and stalls its input; the sender drains it twice.
// ----------------------------------------------------------------------------
module tb_wifi_frame_airtime_top;

  localparam int N_RANDOM     = 600;
  localparam int CALM_TAIL    = 100;      // last random frames run without idling
  localparam int HOLD_CYCLES  = 64;       // long result-side hold-off
  localparam int HOLD_AT      = 150;      // random frame index that starts it
  localparam int DRAIN_AT     = 320;      // random frame index after which we drain
  localparam int SETTLE       = 24;       // > pipeline latency
  localparam int CYCLE_LIMIT  = 200000;

  // DSSS/CCK rates and overheads, 100 kbps units / microseconds
  localparam int unsigned DSSS_1M   = 10;
  localparam int unsigned DSSS_2M   = 20;
  localparam int unsigned CCK_5M5   = 55;
  localparam int unsigned CCK_11M   = 110;
  localparam int unsigned SIFS_DSSS = 10;
  localparam int unsigned PLCP_SHORT = 72 + 24;
  localparam int unsigned PLCP_LONG  = 144 + 48;
  localparam int unsigned OFDM_HEAD  = 16 + 16 + 4;  // SIFS, preamble, SIGNAL
  localparam int unsigned OFDM_XTRA  = 16 + 6;       // service and tail bits
  localparam int unsigned HT_MCS_CNT = 32;

  // HT rates in 100 kbps units, column = {bw40, short gi}
  localparam int unsigned HT_RATES [32][4] = '{
    '{  65,   72,  135,  150}, '{ 130,  144,  270,  300},
    '{ 195,  217,  405,  450}, '{ 260,  289,  540,  600},
    '{ 390,  433,  810,  900}, '{ 520,  578, 1080, 1200},
    '{ 585,  650, 1215, 1350}, '{ 650,  722, 1350, 1500},
    '{ 130,  144,  270,  300}, '{ 260,  289,  540,  600},
    '{ 390,  433,  810,  900}, '{ 520,  578, 1080, 1200},
    '{ 780,  867, 1620, 1800}, '{1040, 1156, 2160, 2400},
    '{1170, 1300, 2430, 2700}, '{1300, 1444, 2700, 3000},
    '{ 195,  217,  405,  450}, '{ 390,  433,  810,  900},
    '{ 585,  650, 1215, 1350}, '{ 780,  867, 1620, 1800},
    '{1170, 1300, 2430, 2700}, '{1560, 1733, 3240, 3600},
    '{1755, 1950, 3645, 4050}, '{1950, 2167, 4050, 4500},
    '{ 260,  288,  540,  600}, '{ 520,  576, 1080, 1200},
    '{ 780,  868, 1620, 1800}, '{1040, 1156, 2160, 2400},
    '{1560, 1732, 3240, 3600}, '{2080, 2312, 4320, 4800},
    '{2340, 2600, 4860, 5400}, '{2600, 2888, 5400, 6000}
  };

  typedef struct packed {
    logic [wfa_pkg::LEN_W-1:0]   frame_length;
    logic                        is_legacy_rate;
    logic [wfa_pkg::LRATE_W-1:0] legacy_rate;
    logic [wfa_pkg::MCS_W-1:0]   mcs_index;
    logic [wfa_pkg::BW_W-1:0]    bandwidth_code;
    logic                        short_gi;
    logic                        short_plcp;
  } frame_t;

  typedef struct packed {
    logic [wfa_pkg::DUR_W-1:0] duration_us;
    logic                      rate_error;
  } airtime_t;

  // directed row: frame, then a typed expectation where one is given
  typedef struct packed {
    frame_t   frame;
    logic     typed;
    airtime_t want;
  } frame_row_t;

  localparam int N_ROWS = 23;
  // fields: len, legacy, lrate, mcs, bw, sgi, spre | typed, {dur, err}
  localparam frame_row_t DIRECTED [N_ROWS] = '{
    // zero legacy rate -> error
    '{'{16'd100,   1'b1, 8'd0,   8'd3,   2'd0, 1'b0, 1'b0}, 1'b1, '{21'd0, 1'b1}},
    // unknown MCS -> error
    '{'{16'd100,   1'b0, 8'd2,   8'd32,  2'd0, 1'b0, 1'b0}, 1'b1, '{21'd0, 1'b1}},
    '{'{16'd65535, 1'b0, 8'd255, 8'd255, 2'd3, 1'b1, 1'b1}, 1'b1, '{21'd0, 1'b1}},
    // zero legacy rate wins over a valid MCS
    '{'{16'd0,     1'b1, 8'd0,   8'd7,   2'd1, 1'b1, 1'b1}, 1'b1, '{21'd0, 1'b1}},
    // 1 Mbps, empty frame, long and short preamble
    '{'{16'd0,     1'b1, 8'd2,   8'd0,   2'd0, 1'b0, 1'b0}, 1'b1, '{21'd234, 1'b0}},
    '{'{16'd0,     1'b1, 8'd2,   8'd0,   2'd0, 1'b0, 1'b1}, 1'b1, '{21'd138, 1'b0}},
    // slowest OFDM rate (0.5 Mbps), empty and longest frame
    '{'{16'd0,     1'b1, 8'd1,   8'd0,   2'd0, 1'b0, 1'b0}, 1'b1, '{21'd144, 1'b0}},
    '{'{16'd65535, 1'b1, 8'd1,   8'd0,   2'd0, 1'b0, 1'b0}, 1'b1, '{21'd1048704, 1'b0}},
    // remaining DSSS/CCK rates
    '{'{16'd1500,  1'b1, 8'd4,   8'd0,   2'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{16'd1500,  1'b1, 8'd11,  8'd0,   2'd0, 1'b0, 1'b1}, 1'b0, '0},
    '{'{16'd65535, 1'b1, 8'd22,  8'd0,   2'd0, 1'b0, 1'b0}, 1'b0, '0},
    // legacy OFDM rates; preamble bit is a don't care here
    '{'{16'd1500,  1'b1, 8'd12,  8'd0,   2'd0, 1'b0, 1'b1}, 1'b0, '0},
    '{'{16'd65535, 1'b1, 8'd255, 8'd0,   2'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{16'd0,     1'b1, 8'd108, 8'd0,   2'd0, 1'b0, 1'b0}, 1'b0, '0},
    // MCS fields ignored on the legacy path
    '{'{16'd777,   1'b1, 8'd22,  8'd255, 2'd3, 1'b1, 1'b1}, 1'b0, '0},
    // HT corners over bandwidth codes and guard interval
    '{'{16'd1500,  1'b0, 8'd0,   8'd0,   2'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{16'd65535, 1'b0, 8'd0,   8'd0,   2'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{16'd0,     1'b0, 8'd0,   8'd0,   2'd1, 1'b1, 1'b0}, 1'b0, '0},
    '{'{16'd65535, 1'b0, 8'd0,   8'd31,  2'd1, 1'b1, 1'b1}, 1'b0, '0},
    '{'{16'd1,     1'b0, 8'd0,   8'd31,  2'd2, 1'b1, 1'b0}, 1'b0, '0},
    '{'{16'd200,   1'b0, 8'd0,   8'd24,  2'd3, 1'b0, 1'b0}, 1'b0, '0},
    // legacy rate field ignored on the HT path
    '{'{16'd1000,  1'b0, 8'd0,   8'd15,  2'd1, 1'b0, 1'b0}, 1'b0, '0},
    '{'{16'd65535, 1'b0, 8'd2,   8'd7,   2'd0, 1'b1, 1'b1}, 1'b0, '0}
  };

  logic clk;
  logic rst_n;

  wfa_in_if  in_chan ();
  wfa_out_if out_chan ();

  wifi_frame_airtime_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  airtime_t pending_airtime [$];   // expected results, oldest first
  int       mismatch_cnt = 0;
  bit       idle_ok      = 1'b1;   // random idling allowed on both sides
  bit       hold_req     = 1'b0;   // asks the result side for a long hold-off
  int       cycle_cnt    = 0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Expected air time of one frame, SIFS included.
  function automatic airtime_t calc_airtime(frame_t f);
    longint unsigned rate;
    longint unsigned bits;
    longint unsigned dur;
    logic [1:0]      col;
    airtime_t        r;
    rate = 0;
    if (f.is_legacy_rate) begin
      rate = 64'(f.legacy_rate) * 5;
    end else if (f.mcs_index < HT_MCS_CNT) begin
      col  = {f.bandwidth_code == wfa_pkg::BW_40MHZ, f.short_gi};
      rate = HT_RATES[f.mcs_index[4:0]][col];
    end
    if (rate == 0) begin
      r.duration_us = '0;
      r.rate_error  = 1'b1;
      return r;
    end
    bits = 8 * (64'(f.frame_length) + 4);
    if (rate == DSSS_1M || rate == DSSS_2M || rate == CCK_5M5 || rate == CCK_11M) begin
      dur = SIFS_DSSS + (f.short_plcp ? PLCP_SHORT : PLCP_LONG);
      dur += (bits * 10 + rate - 1) / rate;
    end else begin
      // whole 4 us symbols, ceiling
      dur = OFDM_HEAD + 4 * (((bits + OFDM_XTRA) * 10 + 4 * rate - 1) / (4 * rate));
    end
    r.duration_us = dur[wfa_pkg::DUR_W-1:0];
    r.rate_error  = 1'b0;
    return r;
  endfunction

  // Offer one frame until it transfers, queue what it should produce, then
  // optionally idle or drain the pipeline. valid stays high across
  // back-to-back frames.
  task automatic offer_frame(frame_t f, bit typed, airtime_t want, bit drain);
    in_chan.valid          <= 1'b1;
    in_chan.frame_length   <= f.frame_length;
    in_chan.is_legacy_rate <= f.is_legacy_rate;
    in_chan.legacy_rate    <= f.legacy_rate;
    in_chan.mcs_index      <= f.mcs_index;
    in_chan.bandwidth_code <= f.bandwidth_code;
    in_chan.short_gi       <= f.short_gi;
    in_chan.short_plcp     <= f.short_plcp;
    do @(posedge clk); while (!(in_chan.valid && in_chan.ready));
    pending_airtime.push_back(typed ? want : calc_airtime(f));
    if (drain) begin
      in_chan.valid <= 1'b0;
      while (pending_airtime.size() != 0) @(posedge clk);
    end else if (idle_ok && !hold_req && $urandom_range(0, 4) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Result side: mostly ready, random stall bursts, one long hold-off.
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_ok && $urandom_range(0, 5) == 0) begin
        // random stall burst, ready low through the next loop edge
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(0, 5)) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Result checker: every transfer against the oldest expectation.
  initial begin
    airtime_t exp_r;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        if (pending_airtime.size() == 0) begin
          $error("result transfer with nothing expected: duration_us=%0d rate_error=%0b",
                 out_chan.duration_us, out_chan.rate_error);
          mismatch_cnt++;
        end else begin
          exp_r = pending_airtime.pop_front();
          if (out_chan.duration_us !== exp_r.duration_us) begin
            $error("duration_us: expected %0d, actual %0d",
                   exp_r.duration_us, out_chan.duration_us);
            mismatch_cnt++;
          end
          if (out_chan.rate_error !== exp_r.rate_error) begin
            $error("rate_error: expected %0b, actual %0b",
                   exp_r.rate_error, out_chan.rate_error);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("wifi_frame_airtime_top: mismatch");
    $finish;
  end

  // Stimulus.
  initial begin
    in_chan.valid          <= 1'b0;
    in_chan.frame_length   <= '0;
    in_chan.is_legacy_rate <= 1'b0;
    in_chan.legacy_rate    <= '0;
    in_chan.mcs_index      <= '0;
    in_chan.bandwidth_code <= '0;
    in_chan.short_gi       <= 1'b0;
    in_chan.short_plcp     <= 1'b0;
    rst_n                  <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; drain after the last row
    for (int i = 0; i < N_ROWS; i++) begin
      offer_frame(DIRECTED[i].frame, DIRECTED[i].typed, DIRECTED[i].want,
                  i == N_ROWS - 1);
    end

    // random stream, mostly well-formed rates
    for (int i = 0; i < N_RANDOM; i++) begin
      frame_t      f;
      int unsigned sel;
      f.frame_length   = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 2400));
      f.is_legacy_rate = 1'($urandom);
      f.legacy_rate    = 8'($urandom);
      f.mcs_index      = 8'($urandom);
      f.bandwidth_code = 2'($urandom);
      f.short_gi       = 1'($urandom);
      f.short_plcp     = 1'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        // DSSS/CCK: 1, 2, 5.5, 11 Mbps
        f.is_legacy_rate = 1'b1;
        case ($urandom_range(0, 3))
          0:       f.legacy_rate = 8'd2;
          1:       f.legacy_rate = 8'd4;
          2:       f.legacy_rate = 8'd11;
          default: f.legacy_rate = 8'd22;
        endcase
      end else if (sel < 40) begin
        f.is_legacy_rate = 1'b1;
        if ($urandom_range(0, 15) == 0) f.legacy_rate = '0;
      end else if (sel < 90) begin
        f.is_legacy_rate = 1'b0;
        f.mcs_index      = 8'($urandom_range(0, HT_MCS_CNT - 1));
      end else begin
        f.is_legacy_rate = 1'b0;   // raw index, mostly unknown
      end
      if (i == HOLD_AT) hold_req = 1'b1;
      if (i == N_RANDOM - CALM_TAIL) idle_ok = 1'b0;
      offer_frame(f, 1'b0, '0, i == DRAIN_AT);
    end
    in_chan.valid <= 1'b0;

    while (pending_airtime.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("wifi_frame_airtime_top: match");
    end else begin
      $display("wifi_frame_airtime_top: mismatch");
    end
    $finish;
  end

endmodule
